// ----- rtl/one_lane_bridge_admission_unit_defines.svh -----
// ----------------------------------------------------------------------------
// One-lane bridge admission unit: assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef ONE_LANE_BRIDGE_ADMISSION_UNIT_DEFINES_SVH
`define ONE_LANE_BRIDGE_ADMISSION_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define OLBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olba check failed");

// Consequent must hold in the cycle after the antecedent
`define OLBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olba check failed");

`endif

// ----- rtl/olba_pkg.sv -----
// ----------------------------------------------------------------------------
// olba_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package olba_pkg;

   // queue geometry (QUEUE_DEPTH is a power of two)
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int RAM_DEPTH   = 2 * QUEUE_DEPTH;
   localparam int RAM_AW      = QPTR_W + 1;
   localparam int ID_WIDTH    = 8;
   localparam int CAP_W       = 4;
   localparam int OCC_W       = 4;
   localparam int KIND_W      = 3;
   localparam int ACTION_W    = 2;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd3;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ARRIVE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LEAVE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RETRY  = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_ADMITTED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_QUEUED     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEAVE_DONE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNDERFLOW  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RETRY_DONE = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request payload
      logic arrive;      // evaluate an arrival and emit its beat
      logic leave;       // evaluate an exit and emit its beat
      logic switch_dir;  // flip the flow direction
      logic pop_read;    // read queue head and advance the queue
      logic pop_emit;    // admit the popped head and emit its beat
      logic done_emit;   // emit the closing retry beat
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic can_pop;
      logic can_switch;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/olba_ram.sv -----
// ----------------------------------------------------------------------------
// olba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module olba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ----- rtl/olba_ctrl.sv -----
// ----------------------------------------------------------------------------
// olba_ctrl
// Sequencer: accepts one request at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module olba_ctrl
   import olba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [ACTION_W-1:0] req_action,
   output logic                     req_ready,
   input  wire status_type          status,
   output cmd_type                  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_LEAVE,
      ST_RETRY,
      ST_POP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   // take a request only when idle and the output stage is empty
   assign req_ready  = (state_ff == ST_IDLE) && !status.rsp_busy;
   assign req_accept = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               case (req_action)
                  ACT_ARRIVE: state_in = ST_ARRIVE;
                  ACT_LEAVE:  state_in = ST_LEAVE;
                  ACT_RETRY:  state_in = ST_RETRY;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_LEAVE: begin
            cmd.leave = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_RETRY: begin
            // hold until the previous beat has gone
            if (!status.rsp_busy) begin
               if (status.can_pop) begin
                  cmd.pop_read = 1'b1;
                  state_in     = ST_POP;
               end else if (status.can_switch) begin
                  cmd.switch_dir = 1'b1;
               end else begin
                  cmd.done_emit = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_POP: begin
            cmd.pop_emit = 1'b1;
            state_in     = ST_RETRY;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/olba_datapath.sv -----
// ----------------------------------------------------------------------------
// olba_datapath
// Bridge state, per-direction waiting queues and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module olba_datapath
   import olba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CAP_W-1:0]    csr_write_data,
   input  wire logic [ID_WIDTH-1:0] req_car_id,
   input  wire logic                req_car_direction,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [KIND_W-1:0]        rsp_kind,
   output logic [ID_WIDTH-1:0]      rsp_granted_id,
   output logic                     rsp_granted_direction,
   output logic                     rsp_flow_direction,
   output logic [OCC_W-1:0]         rsp_occupancy,
   output logic [QCNT_W-1:0]        rsp_waiting_zero,
   output logic [QCNT_W-1:0]        rsp_waiting_one,
   output logic                     rsp_last
);

   // control state
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              dir_ff, dir_in;
   logic [QPTR_W-1:0] head_ff [2];
   logic [QPTR_W-1:0] head_in [2];
   logic [QPTR_W-1:0] tail_ff [2];
   logic [QPTR_W-1:0] tail_in [2];
   logic [QCNT_W-1:0] cnt_ff  [2];
   logic [QCNT_W-1:0] cnt_in  [2];
   logic [CAP_W-1:0]  admitted_ff, admitted_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                car_dir_ff, car_dir_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_WIDTH-1:0] gid_ff, gid_in;
   logic                gdir_ff, gdir_in;
   logic                last_ff, last_in;

   // queue storage
   logic                ram_we;
   logic [RAM_AW-1:0]   ram_waddr;
   logic [RAM_AW-1:0]   ram_raddr;
   logic [ID_WIDTH-1:0] ram_rdata;

   logic cur_nz;
   logic oth_nz;

   olba_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (id_ff),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   // queue slot addresses: direction selects the half
   assign ram_waddr = {car_dir_ff, tail_ff[car_dir_ff]};
   assign ram_raddr = {dir_ff, head_ff[dir_ff]};

   // status towards the sequencer
   assign cur_nz            = (cnt_ff[dir_ff] != '0);
   assign oth_nz            = (cnt_ff[~dir_ff] != '0);
   assign status.can_pop    = cur_nz && (occ_ff < cap_ff) && (admitted_ff < cap_ff);
   assign status.can_switch = (occ_ff == '0) && !cur_nz && oth_nz && (admitted_ff < cap_ff);
   assign status.rsp_busy   = rsp_valid_ff;

   // next-state logic
   always_comb begin
      cap_in       = cap_ff;
      occ_in       = occ_ff;
      dir_in       = dir_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      admitted_in  = admitted_ff;
      rsp_valid_in = rsp_valid_ff;
      id_in        = id_ff;
      car_dir_in   = car_dir_ff;
      kind_in      = kind_ff;
      gid_in       = gid_ff;
      gdir_in      = gdir_ff;
      last_in      = last_ff;
      ram_we       = 1'b0;

      // configuration write
      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end

      // drop the beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // capture the request
      if (cmd.load) begin
         id_in       = req_car_id;
         car_dir_in  = req_car_direction;
         admitted_in = '0;
      end

      // arrival: admit, switch and admit, queue or drop
      if (cmd.arrive) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b1;
         gid_in       = id_ff;
         gdir_in      = car_dir_ff;
         if ((occ_ff < cap_ff) && (dir_ff == car_dir_ff)) begin
            occ_in  = occ_ff + 1'b1;
            kind_in = KIND_ADMITTED;
         end else if ((occ_ff == '0) && (dir_ff != car_dir_ff)) begin
            dir_in  = car_dir_ff;
            occ_in  = OCC_W'(1);
            kind_in = KIND_ADMITTED;
         end else if (!cnt_ff[car_dir_ff][QCNT_W-1]) begin
            ram_we              = 1'b1;
            tail_in[car_dir_ff] = tail_ff[car_dir_ff] + 1'b1;
            cnt_in[car_dir_ff]  = cnt_ff[car_dir_ff] + 1'b1;
            kind_in             = KIND_QUEUED;
         end else begin
            kind_in = KIND_DROPPED;
         end
      end

      // exit: decrement or flag underflow
      if (cmd.leave) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b1;
         gid_in       = '0;
         gdir_in      = 1'b0;
         if (occ_ff == '0) begin
            kind_in = KIND_UNDERFLOW;
         end else begin
            occ_in  = occ_ff - 1'b1;
            kind_in = KIND_LEAVE_DONE;
         end
      end

      // turn the flow round
      if (cmd.switch_dir) begin
         dir_in = ~dir_ff;
      end

      // read the head and advance the queue
      if (cmd.pop_read) begin
         head_in[dir_ff] = head_ff[dir_ff] + 1'b1;
         cnt_in[dir_ff]  = cnt_ff[dir_ff] - 1'b1;
      end

      // admit the popped requester
      if (cmd.pop_emit) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b0;
         kind_in      = KIND_ADMITTED;
         gid_in       = ram_rdata;
         gdir_in      = dir_ff;
         occ_in       = occ_ff + 1'b1;
         admitted_in  = admitted_ff + 1'b1;
      end

      // close the retry tick
      if (cmd.done_emit) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b1;
         kind_in      = KIND_RETRY_DONE;
         gid_in       = '0;
         gdir_in      = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAPACITY_RESET;
         occ_ff       <= '0;
         dir_ff       <= 1'b1;
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         admitted_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         dir_ff       <= dir_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         admitted_ff  <= admitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      car_dir_ff <= car_dir_in;
      kind_ff    <= kind_in;
      gid_ff     <= gid_in;
      gdir_ff    <= gdir_in;
      last_ff    <= last_in;
   end

   // bridge state only moves while no beat is pending, so it is shown directly
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_granted_id        = gid_ff;
   assign rsp_granted_direction = gdir_ff;
   assign rsp_flow_direction    = dir_ff;
   assign rsp_occupancy         = occ_ff;
   assign rsp_waiting_zero      = cnt_ff[0];
   assign rsp_waiting_one       = cnt_ff[1];
   assign rsp_last              = last_ff;

endmodule

`default_nettype wire

// ----- rtl/one_lane_bridge_admission_unit.sv -----
// Arrive and exit each give a single registered beat, set in the ARRIVE or LEAVE state.
// Retry tick: each admitted head is a queue RAM head read, an emit and the beat taken,
// a direction switch and the closing beat a step each; each beat waits for rsp_ready.
// The next request is taken the cycle after the last beat goes; requests never overlap.
// Reset (synchronous): capacity 3, bridge empty, flow direction 1, queues empty.
// ----------------------------------------------------------------------------
// one_lane_bridge_admission_unit
// Admission arbiter for a one-direction-at-a-time shared lane with capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module one_lane_bridge_admission_unit
   import olba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CAP_W-1:0]    csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [ID_WIDTH-1:0] req_car_id,
   input  wire logic                req_car_direction,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [KIND_W-1:0]        rsp_kind,
   output logic [ID_WIDTH-1:0]      rsp_granted_id,
   output logic                     rsp_granted_direction,
   output logic                     rsp_flow_direction,
   output logic [OCC_W-1:0]         rsp_occupancy,
   output logic [QCNT_W-1:0]        rsp_waiting_zero,
   output logic [QCNT_W-1:0]        rsp_waiting_one,
   output logic                     rsp_last
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   olba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // state, queues and response register
   olba_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_car_id            (req_car_id),
      .req_car_direction     (req_car_direction),
      .cmd                   (cmd),
      .status                (status),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_kind              (rsp_kind),
      .rsp_granted_id        (rsp_granted_id),
      .rsp_granted_direction (rsp_granted_direction),
      .rsp_flow_direction    (rsp_flow_direction),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_waiting_zero      (rsp_waiting_zero),
      .rsp_waiting_one       (rsp_waiting_one),
      .rsp_last              (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/olba_checker.sv -----
// ----------------------------------------------------------------------------
// olba_checker
// Port-level checks on the admission unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_lane_bridge_admission_unit_defines.svh"

module olba_checker
   import olba_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [KIND_W-1:0]   rsp_kind,
   input wire logic [ID_WIDTH-1:0] rsp_granted_id,
   input wire logic                rsp_granted_direction,
   input wire logic                rsp_flow_direction,
   input wire logic [OCC_W-1:0]    rsp_occupancy,
   input wire logic [QCNT_W-1:0]   rsp_waiting_zero,
   input wire logic [QCNT_W-1:0]   rsp_waiting_one,
   input wire logic                rsp_last
);

   logic [KIND_W+ID_WIDTH+OCC_W+2*QCNT_W+2:0] rsp_beat;

   // whole response payload, for the hold check
   assign rsp_beat = {rsp_kind, rsp_granted_id, rsp_granted_direction, rsp_flow_direction,
                      rsp_occupancy, rsp_waiting_zero, rsp_waiting_one, rsp_last};

   // a stalled beat holds its payload
   `OLBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))

   // no request is taken while a beat is pending
   `OLBA_ASSERT_NOW(a_no_accept_busy, clock, reset, req_valid && req_ready, !rsp_valid)

   // a beat without last is always a retry admission
   `OLBA_ASSERT_NOW(a_mid_is_admit, clock, reset, rsp_valid && !rsp_last, rsp_kind == KIND_ADMITTED)

   // the tick is still running after a beat without last
   `OLBA_ASSERT_NEXT(a_busy_after_mid, clock, reset, rsp_valid && rsp_ready && !rsp_last, !req_ready)

   // reset empties the output stage
   `OLBA_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind one_lane_bridge_admission_unit olba_checker u_checker (.*);

`default_nettype wire

// ----- dv/tb_one_lane_bridge_admission_unit.sv -----
// ----------------------------------------------------------------------------
// tb_one_lane_bridge_admission_unit
// Self-checking bench for the one-lane bridge admission unit. A scripted
// opening covers underflow, queueing, a full queue, a lowered and a zero
// capacity, direction switches and a retry at its widest. Random phases
// follow, each under a fresh capacity. Every response beat is checked field
// by field against an in-bench model of the bridge, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_lane_bridge_admission_unit;
   import olba_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 40;
   localparam int N_PHASES        = 9;
   localparam int ITEMS_PER_PHASE = 24;

   // one response beat as the block presents it
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ID_WIDTH-1:0] id;
      logic                gdir;
      logic                flow;
      logic [OCC_W-1:0]    occ;
      logic [QCNT_W-1:0]   w0;
      logic [QCNT_W-1:0]   w1;
      logic                last;
   } bridge_beat_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   // one scripted step; a capacity row carries the new value in id
   typedef struct packed {
      row_op_type          op;
      logic [ACTION_W-1:0] action;
      logic [ID_WIDTH-1:0] id;
      logic                dir;
      logic [4:0]          reps;
      logic                fixed;
      bridge_beat_type     beat;
   } stim_row_type;

   localparam bridge_beat_type NO_BEAT = '0;
   localparam int N_ROWS = 34;

   stim_row_type script [N_ROWS] = '{
      // empty bridge: exit underflows, retry has nothing to admit
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1, 1'b1,
        '{KIND_UNDERFLOW, 8'h00, 1'b0, 1'b1, 4'd0, 5'd0, 5'd0, 1'b1}},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1, 1'b1,
        '{KIND_RETRY_DONE, 8'h00, 1'b0, 1'b1, 4'd0, 5'd0, 5'd0, 1'b1}},
      '{ROW_ITEM, ACT_ARRIVE, 8'hFF, 1'b1, 5'd1, 1'b1,
        '{KIND_ADMITTED, 8'hFF, 1'b1, 1'b1, 4'd1, 5'd0, 5'd0, 1'b1}},
      '{ROW_ITEM, ACT_ARRIVE, 8'h00, 1'b0, 5'd1, 1'b1,
        '{KIND_QUEUED, 8'h00, 1'b0, 1'b1, 4'd1, 5'd1, 5'd0, 1'b1}},
      '{ROW_ITEM, ACT_ARRIVE, 8'hAA, 1'b1, 5'd2,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'h5A, 1'b1, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_UNUSED, 8'h3C, 1'b1, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      // capacity lowered below the occupancy
      '{ROW_CSR,  ACT_ARRIVE, 8'd1,  1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'h77, 1'b1, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd2,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      // zero capacity: only an opposite arrival on an empty bridge gets on
      '{ROW_CSR,  ACT_ARRIVE, 8'd0,  1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'h01, 1'b1, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'h02, 1'b1, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'h03, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      // widest capacity: drain one queue, then switch to the other
      '{ROW_CSR,  ACT_ARRIVE, 8'd15, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      // fill the direction 0 queue, then overflow it
      '{ROW_CSR,  ACT_ARRIVE, 8'd1,  1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'hC0, 1'b0, 5'd16, 1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_ARRIVE, 8'hE5, 1'b0, 5'd1, 1'b1,
        '{KIND_DROPPED, 8'hE5, 1'b0, 1'b1, 4'd2, 5'd16, 5'd0, 1'b1}},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd2,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      // full retry: fifteen admissions and the closing beat
      '{ROW_CSR,  ACT_ARRIVE, 8'd15, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_LEAVE,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT},
      '{ROW_ITEM, ACT_RETRY,  8'h00, 1'b0, 5'd1,  1'b0, NO_BEAT}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CAP_W-1:0]    csr_write_data;
   logic                req_valid;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action;
   logic [ID_WIDTH-1:0] req_car_id;
   logic                req_car_direction;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [KIND_W-1:0]   rsp_kind;
   logic [ID_WIDTH-1:0] rsp_granted_id;
   logic                rsp_granted_direction;
   logic                rsp_flow_direction;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic [QCNT_W-1:0]   rsp_waiting_zero;
   logic [QCNT_W-1:0]   rsp_waiting_one;
   logic                rsp_last;

   // bridge model state
   logic [CAP_W-1:0]    lane_cap  = CAPACITY_RESET;
   logic [OCC_W-1:0]    lane_occ  = '0;
   logic                lane_flow = 1'b1;
   logic [ID_WIDTH-1:0] wait_ids   [2][QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wait_head  [2] = '{'0, '0};
   logic [QPTR_W-1:0]   wait_tail  [2] = '{'0, '0};
   logic [QCNT_W-1:0]   wait_count [2] = '{'0, '0};

   bridge_beat_type expected_beats [$];
   bit              calm = 1'b0;
   int              mismatches = 0;
   int              requests_sent = 0;
   int              beats_seen = 0;
   int              settings_used = 0;

   one_lane_bridge_admission_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_car_id            (req_car_id),
      .req_car_direction     (req_car_direction),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_granted_id        (rsp_granted_id),
      .rsp_granted_direction (rsp_granted_direction),
      .rsp_flow_direction    (rsp_flow_direction),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_waiting_zero      (rsp_waiting_zero),
      .rsp_waiting_one       (rsp_waiting_one),
      .rsp_last              (rsp_last)
   );

   always #1 clock = ~clock;

   // queue a beat built from the current model state
   task automatic push_beat(input logic [KIND_W-1:0] kind, input logic [ID_WIDTH-1:0] id,
                            input logic gdir, input logic last);
      bridge_beat_type b;
      b = '{kind, id, gdir, lane_flow, lane_occ, wait_count[0], wait_count[1], last};
      expected_beats.push_back(b);
   endtask

   // advance the bridge model by one request and queue the beats it causes
   task automatic predict_admission(input logic [ACTION_W-1:0] action,
                                    input logic [ID_WIDTH-1:0] id, input logic dir);
      int                  admitted;
      logic                cur;
      logic [ID_WIDTH-1:0] head_id;
      case (action)
         ACT_ARRIVE: begin
            if (lane_occ < lane_cap && lane_flow == dir) begin
               lane_occ = lane_occ + 1'b1;
               push_beat(KIND_ADMITTED, id, dir, 1'b1);
            end else if (lane_occ == 0 && lane_flow != dir) begin
               lane_flow = dir;
               lane_occ  = OCC_W'(1);
               push_beat(KIND_ADMITTED, id, dir, 1'b1);
            end else if (wait_count[dir] < QUEUE_DEPTH) begin
               wait_ids[dir][wait_tail[dir]] = id;
               wait_tail[dir]  = wait_tail[dir] + 1'b1;
               wait_count[dir] = wait_count[dir] + 1'b1;
               push_beat(KIND_QUEUED, id, dir, 1'b1);
            end else begin
               push_beat(KIND_DROPPED, id, dir, 1'b1);
            end
         end
         ACT_LEAVE: begin
            if (lane_occ == 0) begin
               push_beat(KIND_UNDERFLOW, '0, 1'b0, 1'b1);
            end else begin
               lane_occ = lane_occ - 1'b1;
               push_beat(KIND_LEAVE_DONE, '0, 1'b0, 1'b1);
            end
         end
         ACT_RETRY: begin
            admitted = 0;
            while (admitted < lane_cap) begin
               cur = lane_flow;
               if (wait_count[cur] > 0 && lane_occ < lane_cap) begin
                  head_id = wait_ids[cur][wait_head[cur]];
                  wait_head[cur]  = wait_head[cur] + 1'b1;
                  wait_count[cur] = wait_count[cur] - 1'b1;
                  lane_occ = lane_occ + 1'b1;
                  push_beat(KIND_ADMITTED, head_id, cur, 1'b0);
                  admitted++;
               end else if (lane_occ == 0 && wait_count[cur] == 0 && wait_count[~cur] > 0) begin
                  lane_flow = ~cur;
               end else begin
                  break;
               end
            end
            push_beat(KIND_RETRY_DONE, '0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // present one request beat, hold it until taken, then predict
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [ID_WIDTH-1:0] id, input logic dir);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= action;
      req_car_id        <= id;
      req_car_direction <= dir;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_admission(action, id, dir);
      requests_sent++;
   endtask

   // drain, let the block settle, then write the capacity
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      lane_cap = value;
      settings_used++;
   endtask

   // stall the response channel in random bursts, none in the calm phase
   initial begin : rsp_stall
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // compare every response beat with the oldest prediction
   always @(posedge clock) begin : rsp_check
      bridge_beat_type got;
      bridge_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_granted_id, rsp_granted_direction, rsp_flow_direction,
                 rsp_occupancy, rsp_waiting_zero, rsp_waiting_one, rsp_last};
         beats_seen++;
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing pending, kind", 32'(got.kind), '0);
         end else begin
            want = expected_beats.pop_front();
            if (got.kind !== want.kind)
               report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.id !== want.id)
               report_mismatch("granted_id", 32'(got.id), 32'(want.id));
            if (got.gdir !== want.gdir)
               report_mismatch("granted_direction", 32'(got.gdir), 32'(want.gdir));
            if (got.flow !== want.flow)
               report_mismatch("flow_direction", 32'(got.flow), 32'(want.flow));
            if (got.occ !== want.occ)
               report_mismatch("occupancy", 32'(got.occ), 32'(want.occ));
            if (got.w0 !== want.w0)
               report_mismatch("waiting_zero", 32'(got.w0), 32'(want.w0));
            if (got.w1 !== want.w1)
               report_mismatch("waiting_one", 32'(got.w1), 32'(want.w1));
            if (got.last !== want.last)
               report_mismatch("last", 32'(got.last), 32'(want.last));
         end
      end
   end

   initial begin : stimulus
      int                  i;
      int                  r;
      int                  phase;
      int                  counted;
      int                  pick;
      int                  arrive_pct;
      int                  leave_pct;
      int                  dir_bias;
      logic [CAP_W-1:0]    cap_value;
      logic [ACTION_W-1:0] action;
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_action        = ACT_ARRIVE;
      req_car_id        = '0;
      req_car_direction = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the script; typed rows override the model's prediction
      for (i = 0; i < N_ROWS; i++) begin
         if (script[i].op == ROW_CSR) begin
            set_capacity(script[i].id[CAP_W-1:0]);
         end else begin
            for (r = 0; r < script[i].reps; r++) begin
               send_request(script[i].action, ID_WIDTH'(script[i].id + r), script[i].dir);
               if (script[i].fixed) begin
                  void'(expected_beats.pop_back());
                  expected_beats.push_back(script[i].beat);
               end
            end
         end
      end

      // random phases, each with its own capacity, traffic mix and direction bias
      for (phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0:       cap_value = 4'd15;
            1:       cap_value = 4'd0;
            2:       cap_value = 4'd1;
            default: cap_value = CAP_W'($urandom_range(0, 15));
         endcase
         set_capacity(cap_value);
         calm       = (phase == N_PHASES - 1);
         arrive_pct = $urandom_range(30, 60);
         leave_pct  = $urandom_range(10, 35);
         dir_bias   = $urandom_range(0, 100);
         counted    = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < arrive_pct) action = ACT_ARRIVE;
            else if (pick < arrive_pct + leave_pct) action = ACT_LEAVE;
            else if (pick < 97) action = ACT_RETRY;
            else action = ACT_UNUSED;
            send_request(action, ID_WIDTH'($urandom_range(0, 255)),
                         $urandom_range(0, 99) < dir_bias);
            if (action != ACT_UNUSED) counted++;
         end
      end

      // drain outstanding beats and watch for strays
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests, %0d response beats checked, %0d capacity writes.",
               requests_sent, beats_seen, settings_used);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches found", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // give up on a hung handshake
   initial begin : watchdog
      #1000000;
      $display("Timed out with %0d beats still pending", expected_beats.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
